[hw/rtl/eca_pkg.sv]
// Package for the eye closure alarm: shared types, register map and reset values.
// No dependencies; imported by eca_back, eye_closure_alarm and the bench.
package eca_pkg;

  localparam int RATIO_W = 16;
  localparam int SUM_W   = 20;
  localparam int CCNT_W  = 5;
  localparam int RUN_W   = 4;
  localparam int WARN_W  = 6;
  localparam int PROD_W  = 29;

  localparam logic [RATIO_W-1:0] RATIO_MAX = {RATIO_W{1'b1}};
  localparam logic [SUM_W-1:0]   SUM_MAX   = {SUM_W{1'b1}};

  // Register map, word index taken from paddr[3:2]
  localparam logic [1:0] REG_THRESHOLD   = 2'd0;
  localparam logic [1:0] REG_CLOSED_RUN  = 2'd1;
  localparam logic [1:0] REG_ALARM_HOLD  = 2'd2;
  localparam logic [1:0] REG_CALIB       = 2'd3;

  localparam logic [8:0] THRESHOLD_RST  = 9'd130;
  localparam logic [3:0] CLOSED_RUN_RST = 4'd7;
  localparam logic [4:0] ALARM_HOLD_RST = 5'd15;
  localparam logic [3:0] CALIB_RST      = 4'd10;

  typedef struct packed {
    logic [8:0] threshold_pct;
    logic [3:0] closed_run_limit;
    logic [4:0] alarm_hold;
    logic [3:0] calib_frames;
  } eca_cfg_t;

  typedef enum logic [1:0] {
    PH_CALIB  = 2'd0,
    PH_FINISH = 2'd1,
    PH_DETECT = 2'd2
  } eca_phase_e;

endpackage

[hw/rtl/eye_closure_alarm.sv]
// Eye closure alarm, top level: register port, front, queue and back.
// Depends on eca_pkg, eca_front, eca_fifo and eca_back.
//
// Landmark points enter one beat per cycle, while in_stall_o is low, on the
// input channel (eye_sel_i, coord_x_i, coord_y_i, frame_end_i). Each point
// widens its eye's bounding box; the point marked frame_end closes the frame
// and its box dimensions go into a two-entry queue. The back end divides
// width by height for both eyes bit-serially, one quotient bit per cycle,
// then runs the baseline compare and alarm update. One result beat leaves
// per frame. The back end takes the next frame from the queue only once it
// has finished the last one. Points inside a frame are taken every cycle
// while the queue has room; in_stall_o rises when it holds two frames.
// When out_stall_i is high the result beat holds, and the back end waits in
// its compare step while an earlier beat is held; the front keeps collecting
// points until the queue fills.
// Reset clears the boxes, sums, counters and alarm, and loads the register
// defaults. Registers are to be written over the APB port only while the
// block is idle; the block itself does not enforce this.
module eye_closure_alarm #(
  parameter int COORD_BITS      = 12,
  parameter int RATIO_FRAC_BITS = 8
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [3:0]            paddr,
  input  logic [31:0]           pwdata,
  output logic [31:0]           prdata,
  output logic                  pready,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  logic                  eye_sel_i,
  input  logic [COORD_BITS-1:0] coord_x_i,
  input  logic [COORD_BITS-1:0] coord_y_i,
  input  logic                  frame_end_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output logic                  alarm_on_o,
  output logic [15:0]           left_ratio_o,
  output logic [15:0]           right_ratio_o,
  output logic [1:0]            phase_o,
  output logic                  closed_frame_o
);
  import eca_pkg::*;

  localparam int DW = 4 * COORD_BITS;

  eca_cfg_t        cfg_q;
  logic            wr_en;
  logic            full, push, deq_valid, deq_pop;
  logic [DW-1:0]   push_data, deq_data;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.threshold_pct    <= THRESHOLD_RST;
      cfg_q.closed_run_limit <= CLOSED_RUN_RST;
      cfg_q.alarm_hold       <= ALARM_HOLD_RST;
      cfg_q.calib_frames     <= CALIB_RST;
    end else if (wr_en) begin
      case (paddr[3:2])
        REG_THRESHOLD:  cfg_q.threshold_pct    <= pwdata[8:0];
        REG_CLOSED_RUN: cfg_q.closed_run_limit <= pwdata[3:0];
        REG_ALARM_HOLD: cfg_q.alarm_hold       <= pwdata[4:0];
        REG_CALIB:      cfg_q.calib_frames     <= pwdata[3:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      REG_THRESHOLD:  prdata = {23'd0, cfg_q.threshold_pct};
      REG_CLOSED_RUN: prdata = {28'd0, cfg_q.closed_run_limit};
      REG_ALARM_HOLD: prdata = {27'd0, cfg_q.alarm_hold};
      REG_CALIB:      prdata = {28'd0, cfg_q.calib_frames};
      default:        prdata = '0;
    endcase
  end

  eca_front #(
    .COORD_BITS(COORD_BITS)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .eye_sel_i   (eye_sel_i),
    .coord_x_i   (coord_x_i),
    .coord_y_i   (coord_y_i),
    .frame_end_i (frame_end_i),
    .full_i      (full),
    .push_o      (push),
    .push_data_o (push_data)
  );

  eca_fifo #(
    .WIDTH(DW)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (push_data),
    .full_o  (full),
    .pop_i   (deq_pop),
    .valid_o (deq_valid),
    .data_o  (deq_data)
  );

  eca_back #(
    .COORD_BITS      (COORD_BITS),
    .RATIO_FRAC_BITS (RATIO_FRAC_BITS)
  ) u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_i          (cfg_q),
    .deq_valid_i    (deq_valid),
    .deq_data_i     (deq_data),
    .deq_pop_o      (deq_pop),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .alarm_on_o     (alarm_on_o),
    .left_ratio_o   (left_ratio_o),
    .right_ratio_o  (right_ratio_o),
    .phase_o        (phase_o),
    .closed_frame_o (closed_frame_o)
  );

endmodule

[hw/rtl/eca_front.sv]
// Front part: per-eye bounding boxes, width and height at frame end.
// Pushes frame dimensions into eca_fifo; no package dependency.
module eca_front #(
  parameter int COORD_BITS = 12
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  output logic                    in_stall_o,
  input  logic                    eye_sel_i,
  input  logic [COORD_BITS-1:0]   coord_x_i,
  input  logic [COORD_BITS-1:0]   coord_y_i,
  input  logic                    frame_end_i,
  input  logic                    full_i,
  output logic                    push_o,
  output logic [4*COORD_BITS-1:0] push_data_o
);

  localparam logic [COORD_BITS-1:0] CMAX = {COORD_BITS{1'b1}};

  logic [COORD_BITS-1:0] minx_q[2], miny_q[2], maxx_q[2], maxy_q[2];
  logic [COORD_BITS-1:0] minx_n[2], miny_n[2], maxx_n[2], maxy_n[2];
  logic [COORD_BITS-1:0] wid[2], hgt[2];
  logic                  accept;

  assign in_stall_o = full_i;
  assign accept     = in_valid_i && !full_i;
  assign push_o     = accept && frame_end_i;

  always_comb begin
    for (int e = 0; e < 2; e++) begin
      minx_n[e] = minx_q[e];
      miny_n[e] = miny_q[e];
      maxx_n[e] = maxx_q[e];
      maxy_n[e] = maxy_q[e];
      if (eye_sel_i == e[0]) begin
        if (coord_x_i < minx_q[e]) minx_n[e] = coord_x_i;
        if (coord_y_i < miny_q[e]) miny_n[e] = coord_y_i;
        if (coord_x_i > maxx_q[e]) maxx_n[e] = coord_x_i;
        if (coord_y_i > maxy_q[e]) maxy_n[e] = coord_y_i;
      end
      wid[e] = (maxx_n[e] >= minx_n[e]) ? maxx_n[e] - minx_n[e] : '0;
      hgt[e] = (maxy_n[e] >= miny_n[e]) ? maxy_n[e] - miny_n[e] : '0;
    end
  end

  assign push_data_o = {wid[0], hgt[0], wid[1], hgt[1]};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int e = 0; e < 2; e++) begin
        minx_q[e] <= CMAX;
        miny_q[e] <= CMAX;
        maxx_q[e] <= '0;
        maxy_q[e] <= '0;
      end
    end else if (accept) begin
      for (int e = 0; e < 2; e++) begin
        if (frame_end_i) begin
          minx_q[e] <= CMAX;
          miny_q[e] <= CMAX;
          maxx_q[e] <= '0;
          maxy_q[e] <= '0;
        end else begin
          minx_q[e] <= minx_n[e];
          miny_q[e] <= miny_n[e];
          maxx_q[e] <= maxx_n[e];
          maxy_q[e] <= maxy_n[e];
        end
      end
    end
  end

endmodule

[hw/rtl/eca_fifo.sv]
// Two-entry queue of frame dimensions between front and back.
// Head entry is always presented; no package dependency.
module eca_fifo #(
  parameter int WIDTH = 48
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic             valid_o,
  output logic [WIDTH-1:0] data_o
);

  logic [1:0]       count_q;
  logic [WIDTH-1:0] head_q, tail_q;

  assign full_o  = (count_q == 2'd2);
  assign valid_o = (count_q != 2'd0);
  assign data_o  = head_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= 2'd0;
    end else begin
      count_q <= count_q + {1'b0, push_i} - {1'b0, pop_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_i) begin
      if (count_q == 2'd2) begin
        head_q <= tail_q;
        if (push_i) tail_q <= data_i;
      end else if (push_i) begin
        head_q <= data_i;
      end
    end else if (push_i) begin
      if (count_q == 2'd0) head_q <= data_i;
      else tail_q <= data_i;
    end
  end

endmodule

[hw/rtl/eca_back.sv]
// Back part: bit-serial ratio divides, baseline compare, calibration and alarm state.
// Depends on eca_pkg; holds the result register for the output channel.
module eca_back #(
  parameter int COORD_BITS      = 12,
  parameter int RATIO_FRAC_BITS = 8
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  eca_pkg::eca_cfg_t       cfg_i,
  input  logic                    deq_valid_i,
  input  logic [4*COORD_BITS-1:0] deq_data_i,
  output logic                    deq_pop_o,
  output logic                    out_valid_o,
  input  logic                    out_stall_i,
  output logic                    alarm_on_o,
  output logic [15:0]             left_ratio_o,
  output logic [15:0]             right_ratio_o,
  output logic [1:0]              phase_o,
  output logic                    closed_frame_o
);
  import eca_pkg::*;

  localparam int C  = COORD_BITS;
  localparam int QW = COORD_BITS + RATIO_FRAC_BITS;
  localparam int CW = $clog2(QW);
  localparam int EW = (QW > RATIO_W) ? QW : RATIO_W;

  typedef enum logic [1:0] {ST_IDLE, ST_DIV, ST_MUL, ST_CMP} state_e;

  state_e            state_q;
  logic [CW-1:0]     cnt_q;
  logic [QW-1:0]     dvd_q[2];
  logic [C-1:0]      rem_q[2];
  logic [C-1:0]      dvs_q[2];
  logic [QW-1:0]     dvd_d[2];
  logic [C-1:0]      rem_d[2];
  logic [RATIO_W-1:0] ratio_c[2];
  logic [RATIO_W-1:0] ratio_q[2];
  logic [19:0]       lhs_q[2];
  logic [PROD_W-1:0] rhs_q[2];
  logic              above[2];

  logic [SUM_W-1:0]  sum_q[2], sum_d[2];
  logic [CCNT_W-1:0] ccnt_q, ccnt_d;
  logic [RUN_W-1:0]  run_q, run_d;
  logic [WARN_W-1:0] warn_q, warn_d;
  logic              alarm_q, alarm_d;
  logic              closed_c;
  eca_phase_e        phase_c;
  logic              out_free;
  logic [SUM_W:0]    sum_ext[2];
  logic [C:0]        rem_sh[2];

  assign deq_pop_o = (state_q == ST_IDLE) && deq_valid_i;
  assign out_free  = !out_valid_o || !out_stall_i;

  // Restoring divide step, one quotient bit per cycle for each eye; also ratio saturation, baseline compare and sum
  always_comb begin
    for (int e = 0; e < 2; e++) begin
      rem_sh[e] = {rem_q[e], dvd_q[e][QW-1]};
      if (rem_sh[e] >= {1'b0, dvs_q[e]}) begin
        rem_d[e] = C'(rem_sh[e] - {1'b0, dvs_q[e]});
        dvd_d[e] = {dvd_q[e][QW-2:0], 1'b1};
      end else begin
        rem_d[e] = rem_sh[e][C-1:0];
        dvd_d[e] = {dvd_q[e][QW-2:0], 1'b0};
      end
      if (dvs_q[e] == '0) ratio_c[e] = RATIO_MAX;
      else if (EW'(dvd_q[e]) > EW'(RATIO_MAX)) ratio_c[e] = RATIO_MAX;
      else ratio_c[e] = RATIO_W'(dvd_q[e]);
      above[e] = (PROD_W'(lhs_q[e]) * PROD_W'(100)) > rhs_q[e];
      sum_ext[e] = {1'b0, sum_q[e]} + (SUM_W+1)'(ratio_q[e]);
    end
  end

  // Frame commit: calibration, closure run and alarm hold
  always_comb begin
    sum_d    = sum_q;
    ccnt_d   = ccnt_q;
    run_d    = run_q;
    warn_d   = warn_q;
    alarm_d  = alarm_q;
    closed_c = 1'b0;
    if (ccnt_q < {1'b0, cfg_i.calib_frames}) begin
      phase_c = PH_CALIB;
      for (int e = 0; e < 2; e++) begin
        sum_d[e] = sum_ext[e][SUM_W] ? SUM_MAX : sum_ext[e][SUM_W-1:0];
      end
      ccnt_d = ccnt_q + 1'b1;
    end else if (ccnt_q == {1'b0, cfg_i.calib_frames}) begin
      phase_c = PH_FINISH;
      ccnt_d  = ccnt_q + 1'b1;
    end else begin
      phase_c = PH_DETECT;
      if (above[0] && above[1]) begin
        closed_c = 1'b1;
        if (run_q < cfg_i.closed_run_limit) begin
          run_d = run_q + 1'b1;
        end else begin
          alarm_d = 1'b1;
          warn_d  = warn_q + 1'b1;
          run_d   = '0;
        end
      end else begin
        run_d = '0;
      end
    end
    if (warn_d != '0) begin
      if (warn_d >= {1'b0, cfg_i.alarm_hold}) begin
        alarm_d = 1'b0;
        warn_d  = '0;
      end else begin
        warn_d = warn_d + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      sum_q[0]    <= '0;
      sum_q[1]    <= '0;
      ccnt_q      <= '0;
      run_q       <= '0;
      warn_q      <= '0;
      alarm_q     <= 1'b0;
      out_valid_o <= 1'b0;
    end else begin
      if ((state_q == ST_CMP) && out_free) begin
        out_valid_o <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_o <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (deq_valid_i) begin
            cnt_q   <= '0;
            state_q <= ST_DIV;
          end
        end
        ST_DIV: begin
          cnt_q <= cnt_q + 1'b1;
          if (cnt_q == CW'(QW - 1)) state_q <= ST_MUL;
        end
        ST_MUL: begin
          state_q <= ST_CMP;
        end
        ST_CMP: begin
          if (out_free) begin
            sum_q       <= sum_d;
            ccnt_q      <= ccnt_d;
            run_q       <= run_d;
            warn_q      <= warn_d;
            alarm_q     <= alarm_d;
            state_q     <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      ST_IDLE: begin
        dvd_q[0] <= {deq_data_i[4*C-1:3*C], RATIO_FRAC_BITS'(0)};
        dvs_q[0] <= deq_data_i[3*C-1:2*C];
        dvd_q[1] <= {deq_data_i[2*C-1:C], RATIO_FRAC_BITS'(0)};
        dvs_q[1] <= deq_data_i[C-1:0];
        rem_q[0] <= '0;
        rem_q[1] <= '0;
      end
      ST_DIV: begin
        dvd_q <= dvd_d;
        rem_q <= rem_d;
      end
      ST_MUL: begin
        for (int e = 0; e < 2; e++) begin
          ratio_q[e] <= ratio_c[e];
          lhs_q[e]   <= 20'(ratio_c[e]) * 20'(cfg_i.calib_frames);
          rhs_q[e]   <= PROD_W'(cfg_i.threshold_pct) * PROD_W'(sum_q[e]);
        end
      end
      ST_CMP: begin
        if (out_free) begin
          alarm_on_o     <= alarm_d;
          left_ratio_o   <= ratio_q[0];
          right_ratio_o  <= ratio_q[1];
          phase_o        <= phase_c;
          closed_frame_o <= closed_c;
        end
      end
      default: begin
      end
    endcase
  end

endmodule

[bench/tb_eye_closure_alarm.sv]
// Self-checking bench for eye_closure_alarm: landmark beats in, one frame result out.
// Uses eca_pkg for register indexes, reset values, config struct and phase codes.
// Directed table first, then random frames over several register settings.
`timescale 1ns / 1ps

module tb_eye_closure_alarm;
  import eca_pkg::*;

  localparam logic EYE_L = 1'b0;
  localparam logic EYE_R = 1'b1;
  localparam int   SETTLE = 40;
  localparam int   DIR_N = 25;
  localparam int   N_PHASES = 7;

  typedef struct packed {
    logic        sel;
    logic [11:0] x;
    logic [11:0] y;
    logic        fe;
  } point_t;

  typedef struct packed {
    logic        alarm;
    logic [15:0] lr;
    logic [15:0] rr;
    eca_phase_e  phase;
    logic        closed;
  } frame_res_t;

  typedef struct packed {
    point_t     pt;
    logic       typed;
    frame_res_t res;
  } dir_row_t;

  typedef struct packed {
    logic [11:0] min_x;
    logic [11:0] min_y;
    logic [11:0] max_x;
    logic [11:0] max_y;
  } box_t;

  typedef enum int {OPEN_EYES, SHUT_EYES, NOISE_PTS} frame_kind_e;

  localparam box_t BOX_EMPTY = '{12'hFFF, 12'hFFF, 12'h000, 12'h000};
  localparam frame_res_t NO_RES = '{1'b0, 16'h0000, 16'h0000, PH_CALIB, 1'b0};

  // calib_frames is 2 here, the other registers hold their reset values
  localparam dir_row_t DIR_TAB [DIR_N] = '{
    '{'{EYE_L, 12'd10, 12'd0, 1'b0}, 1'b0, NO_RES},
    '{'{EYE_L, 12'd10, 12'd4095, 1'b0}, 1'b0, NO_RES},
    '{'{EYE_R, 12'd20, 12'd100, 1'b0}, 1'b0, NO_RES},
    '{'{EYE_R, 12'd20, 12'd300, 1'b1}, 1'b1, '{1'b0, 16'h0000, 16'h0000, PH_CALIB, 1'b0}},
    '{'{EYE_L, 12'd0, 12'd0, 1'b0}, 1'b0, NO_RES},
    '{'{EYE_L, 12'd0, 12'd4095, 1'b0}, 1'b0, NO_RES},
    '{'{EYE_R, 12'd4095, 12'd0, 1'b0}, 1'b0, NO_RES},
    '{'{EYE_R, 12'd4095, 12'd4095, 1'b1}, 1'b1, '{1'b0, 16'h0000, 16'h0000, PH_CALIB, 1'b0}},
    '{'{EYE_L, 12'd0, 12'd0, 1'b0}, 1'b0, NO_RES},
    '{'{EYE_L, 12'd4095, 12'd4095, 1'b0}, 1'b0, NO_RES},
    '{'{EYE_R, 12'd4095, 12'd0, 1'b0}, 1'b0, NO_RES},
    '{'{EYE_R, 12'd0, 12'd4095, 1'b1}, 1'b1, '{1'b0, 16'h0100, 16'h0100, PH_FINISH, 1'b0}},
    '{'{EYE_L, 12'd7, 12'd7, 1'b1}, 1'b1, '{1'b0, 16'hFFFF, 16'hFFFF, PH_DETECT, 1'b1}},
    '{'{EYE_L, 12'd0, 12'd10, 1'b0}, 1'b0, NO_RES},
    '{'{EYE_L, 12'd4095, 12'd10, 1'b0}, 1'b0, NO_RES},
    '{'{EYE_R, 12'd1, 12'd2, 1'b0}, 1'b0, NO_RES},
    '{'{EYE_R, 12'd3, 12'd3, 1'b1}, 1'b1, '{1'b0, 16'hFFFF, 16'h0200, PH_DETECT, 1'b1}},
    '{'{EYE_L, 12'd0, 12'd0, 1'b0}, 1'b0, NO_RES},
    '{'{EYE_L, 12'd4095, 12'd1, 1'b0}, 1'b0, NO_RES},
    '{'{EYE_R, 12'd0, 12'd0, 1'b0}, 1'b0, NO_RES},
    '{'{EYE_R, 12'd255, 12'd1, 1'b1}, 1'b1, '{1'b0, 16'hFFFF, 16'hFF00, PH_DETECT, 1'b1}},
    '{'{EYE_L, 12'd5, 12'd0, 1'b0}, 1'b0, NO_RES},
    '{'{EYE_L, 12'd5, 12'd9, 1'b0}, 1'b0, NO_RES},
    '{'{EYE_R, 12'd0, 12'd0, 1'b0}, 1'b0, NO_RES},
    '{'{EYE_R, 12'd9, 12'd9, 1'b1}, 1'b1, '{1'b0, 16'h0000, 16'h0100, PH_DETECT, 1'b0}}
  };

  localparam eca_cfg_t PHASE_CFG [N_PHASES] = '{
    '{9'd130, 4'd7, 5'd15, 4'd2},
    '{9'd511, 4'd0, 5'd0, 4'd0},
    '{9'd100, 4'd15, 5'd31, 4'd15},
    '{9'd400, 4'd3, 5'd5, 4'd15},
    '{9'd0, 4'd0, 5'd0, 4'd15},
    '{9'd150, 4'd1, 5'd1, 4'd1},
    '{THRESHOLD_RST, CLOSED_RUN_RST, ALARM_HOLD_RST, CALIB_RST}
  };
  localparam int PHASE_FRAMES [N_PHASES] = '{20, 8, 34, 12, 6, 8, 14};

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [3:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;
  logic        in_valid_i;
  logic        in_stall_o;
  logic        eye_sel_i;
  logic [11:0] coord_x_i;
  logic [11:0] coord_y_i;
  logic        frame_end_i;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic        alarm_on_o;
  logic [15:0] left_ratio_o;
  logic [15:0] right_ratio_o;
  logic [1:0]  phase_o;
  logic        closed_frame_o;

  eye_closure_alarm dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .eye_sel_i     (eye_sel_i),
    .coord_x_i     (coord_x_i),
    .coord_y_i     (coord_y_i),
    .frame_end_i   (frame_end_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .alarm_on_o    (alarm_on_o),
    .left_ratio_o  (left_ratio_o),
    .right_ratio_o (right_ratio_o),
    .phase_o       (phase_o),
    .closed_frame_o(closed_frame_o)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  eca_cfg_t    cfg = '{THRESHOLD_RST, CLOSED_RUN_RST, ALARM_HOLD_RST, CALIB_RST};
  box_t        eye_box [2] = '{BOX_EMPTY, BOX_EMPTY};
  logic [19:0] base_sum [2] = '{20'd0, 20'd0};
  logic [4:0]  calib_cnt = '0;
  logic [3:0]  run_cnt = '0;
  logic [5:0]  warn_cnt = '0;
  logic        alarm_q = 1'b0;

  frame_res_t  pending_frames [$];
  int          err_cnt = 0;
  bit          calm = 1'b0;
  int          go_left = 0;
  int          hold_left = 0;

  task automatic report(input string msg);
    err_cnt++;
    if (err_cnt <= 10) begin
      $display("%s", msg);
    end
  endtask

  function automatic int pick_idle();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [15:0] box_ratio(box_t b);
    logic [11:0] w;
    logic [11:0] h;
    logic [19:0] q;
    w = (b.max_x >= b.min_x) ? b.max_x - b.min_x : 12'd0;
    h = (b.max_y >= b.min_y) ? b.max_y - b.min_y : 12'd0;
    if (h == 12'd0) return RATIO_MAX;
    q = {w, 8'h00} / {8'h00, h};
    return (q > 20'h0FFFF) ? RATIO_MAX : q[15:0];
  endfunction

  function automatic bit exceeds_baseline(logic [15:0] r, logic [19:0] s);
    longint unsigned lhs;
    longint unsigned rhs;
    lhs = longint'(r) * longint'(cfg.calib_frames) * 100;
    rhs = longint'(cfg.threshold_pct) * longint'(s);
    return lhs > rhs;
  endfunction

  task automatic track_point(input point_t p, output bit done, output frame_res_t r);
    box_t       b;
    logic [15:0] lr;
    logic [15:0] rr;
    logic [20:0] t;
    eca_phase_e ph;
    bit         shut;
    b = eye_box[p.sel];
    if (p.x < b.min_x) b.min_x = p.x;
    if (p.y < b.min_y) b.min_y = p.y;
    if (p.x > b.max_x) b.max_x = p.x;
    if (p.y > b.max_y) b.max_y = p.y;
    eye_box[p.sel] = b;
    done = p.fe;
    r = '0;
    if (!p.fe) return;
    lr = box_ratio(eye_box[EYE_L]);
    rr = box_ratio(eye_box[EYE_R]);
    eye_box[EYE_L] = BOX_EMPTY;
    eye_box[EYE_R] = BOX_EMPTY;
    shut = 1'b0;
    if (calib_cnt < cfg.calib_frames) begin
      ph = PH_CALIB;
      t = base_sum[EYE_L] + lr;
      base_sum[EYE_L] = (t > SUM_MAX) ? SUM_MAX : t[19:0];
      t = base_sum[EYE_R] + rr;
      base_sum[EYE_R] = (t > SUM_MAX) ? SUM_MAX : t[19:0];
      calib_cnt++;
    end else if (calib_cnt == cfg.calib_frames) begin
      ph = PH_FINISH;
      calib_cnt++;
    end else begin
      ph = PH_DETECT;
      if (exceeds_baseline(lr, base_sum[EYE_L]) && exceeds_baseline(rr, base_sum[EYE_R])) begin
        shut = 1'b1;
        if (run_cnt < cfg.closed_run_limit) begin
          run_cnt++;
        end else begin
          alarm_q = 1'b1;
          warn_cnt++;
          run_cnt = '0;
        end
      end else begin
        run_cnt = '0;
      end
    end
    if (warn_cnt != 0) begin
      if (warn_cnt >= cfg.alarm_hold) begin
        alarm_q = 1'b0;
        warn_cnt = '0;
      end else begin
        warn_cnt++;
      end
    end
    r = '{alarm_q, lr, rr, ph, shut};
  endtask

  task automatic push_point(input point_t p, input logic typed, input frame_res_t typed_res);
    bit         done;
    frame_res_t r;
    in_valid_i  <= 1'b1;
    eye_sel_i   <= p.sel;
    coord_x_i   <= p.x;
    coord_y_i   <= p.y;
    frame_end_i <= p.fe;
    do @(posedge clk_i); while (in_stall_o);
    track_point(p, done, r);
    if (done) begin
      pending_frames = {pending_frames, (typed ? typed_res : r)};
    end
  endtask

  task automatic rest(input int n);
    if (n > 0) begin
      in_valid_i <= 1'b0;
      repeat (n) @(posedge clk_i);
    end
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    while (pending_frames.size() != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  task automatic apb_xfer(input logic [1:0] idx, input logic wr, input logic [31:0] wdata,
                          output logic [31:0] rdata);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= {idx, 2'b00};
    pwdata  <= wdata;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    rdata = prdata;
  endtask

  task automatic load_cfg(input eca_cfg_t c);
    logic [1:0]  idx;
    logic [31:0] val;
    logic [31:0] rd;
    for (int k = 0; k < 4; k++) begin
      idx = 2'(k);
      case (idx)
        REG_THRESHOLD:  val = 32'(c.threshold_pct);
        REG_CLOSED_RUN: val = 32'(c.closed_run_limit);
        REG_ALARM_HOLD: val = 32'(c.alarm_hold);
        default:        val = 32'(c.calib_frames);
      endcase
      apb_xfer(idx, 1'b1, val, rd);
      apb_xfer(idx, 1'b0, 32'd0, rd);
      if (rd !== val) begin
        report($sformatf("register %0d read back %h, wrote %h", idx, rd, val));
      end
    end
    psel    <= 1'b0;
    penable <= 1'b0;
    cfg = c;
  endtask

  always @(posedge clk_i) begin : out_side
    frame_res_t want;
    frame_res_t got;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      got = '{alarm_on_o, left_ratio_o, right_ratio_o, eca_phase_e'(phase_o), closed_frame_o};
      if (pending_frames.size() == 0) begin
        report($sformatf("result beat with nothing expected: alarm=%0d left=%h right=%h",
                         got.alarm, got.lr, got.rr));
      end else begin
        want = pending_frames.pop_front();
        if (got !== want) begin
          report($sformatf({"frame: want a=%0d l=%h r=%h ph=%0d c=%0d,",
                            " got a=%0d l=%h r=%h ph=%0d c=%0d"},
                           want.alarm, want.lr, want.rr, want.phase, want.closed,
                           got.alarm, got.lr, got.rr, got.phase, got.closed));
        end
      end
    end
    if (go_left != 0) begin
      out_stall_i <= 1'b0;
      go_left--;
    end else if (hold_left != 0) begin
      out_stall_i <= 1'b1;
      hold_left--;
    end else begin
      out_stall_i <= 1'b0;
      go_left = $urandom_range(1, 8);
      hold_left = calm ? 0 : pick_idle();
    end
  end

  initial begin
    #10_000_000;
    $display("TB_ERROR");
    $finish;
  end

  initial begin
    point_t      pts [$];
    point_t      pt;
    frame_kind_e kind;
    int          w;
    int          h;
    int          n;
    int          x0;
    int          y0;
    int          shut_left;
    int          open_left;
    logic        first;
    bit          in_calib;
    shut_left   = 0;
    open_left   = 0;
    rst_ni      = 1'b0;
    psel        = 1'b0;
    penable     = 1'b0;
    pwrite      = 1'b0;
    paddr       = '0;
    pwdata      = '0;
    in_valid_i  = 1'b0;
    eye_sel_i   = 1'b0;
    coord_x_i   = '0;
    coord_y_i   = '0;
    frame_end_i = 1'b0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    load_cfg('{THRESHOLD_RST, CLOSED_RUN_RST, ALARM_HOLD_RST, 4'd2});
    for (int i = 0; i < DIR_N; i++) begin
      push_point(DIR_TAB[i].pt, DIR_TAB[i].typed, DIR_TAB[i].res);
      rest(pick_idle());
    end

    for (int ph_i = 0; ph_i < N_PHASES; ph_i++) begin
      drain();
      load_cfg(PHASE_CFG[ph_i]);
      for (int f = 0; f < PHASE_FRAMES[ph_i]; f++) begin
        if ($urandom_range(0, 9) == 0) calm = !calm;
        if ($urandom_range(0, 24) == 0) drain();
        in_calib = (calib_cnt <= cfg.calib_frames);
        if (in_calib) begin
          kind = ($urandom_range(0, 9) == 0) ? NOISE_PTS : OPEN_EYES;
        end else begin
          if (shut_left == 0 && open_left == 0) begin
            shut_left = $urandom_range(1, 20);
            open_left = $urandom_range(1, 3);
          end
          if ($urandom_range(0, 19) == 0) begin
            kind = NOISE_PTS;
          end else if (shut_left != 0) begin
            kind = SHUT_EYES;
            shut_left--;
          end else begin
            kind = OPEN_EYES;
            open_left--;
          end
        end
        pts.delete();
        if (kind == NOISE_PTS) begin
          n = $urandom_range(1, 5);
          repeat (n) begin
            pt = '{1'($urandom_range(0, 1)), 12'($urandom_range(0, 4095)),
                   12'($urandom_range(0, 4095)), 1'b0};
            pts = {pts, pt};
          end
        end else begin
          first = 1'($urandom_range(0, 1));
          for (int e = 0; e < 2; e++) begin
            w  = $urandom_range(40, 80);
            h  = (kind == OPEN_EYES) ? $urandom_range(15, 30) : $urandom_range(0, 2);
            x0 = $urandom_range(0, 4095 - w);
            y0 = $urandom_range(0, 4095 - h);
            n  = $urandom_range(1, 3);
            repeat (n) begin
              pt.sel = first ^ e[0];
              pt.fe  = 1'b0;
              case ($urandom_range(0, 3))
                0: begin
                  pt.x = 12'(x0);
                  pt.y = 12'(y0 + $urandom_range(0, h));
                end
                1: begin
                  pt.x = 12'(x0 + w);
                  pt.y = 12'(y0 + $urandom_range(0, h));
                end
                2: begin
                  pt.x = 12'(x0 + $urandom_range(0, w));
                  pt.y = 12'(y0);
                end
                default: begin
                  pt.x = 12'(x0 + $urandom_range(0, w));
                  pt.y = 12'(y0 + h);
                end
              endcase
              pts = {pts, pt};
            end
          end
        end
        pts[pts.size() - 1].fe = 1'b1;
        foreach (pts[i]) begin
          push_point(pts[i], 1'b0, NO_RES);
          rest(calm ? 0 : pick_idle());
        end
      end
    end

    drain();
    if (err_cnt == 0 && pending_frames.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
